@@ rtl/mlr_pkg.sv @@
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared widths, octant codes and the command type of the midpoint line
// rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

    localparam int COORD_BITS = 12;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int DEC_BITS   = COORD_BITS + 5;
    localparam int OCT_BITS   = 3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // bit 2: dx < 0, bit 1: dy < 0, bit 0: steep
    localparam logic [OCT_BITS-1:0] OCT_XP_YP_SHALLOW = 3'd0;
    localparam logic [OCT_BITS-1:0] OCT_XP_YP_STEEP   = 3'd1;
    localparam logic [OCT_BITS-1:0] OCT_XP_YN_SHALLOW = 3'd2;
    localparam logic [OCT_BITS-1:0] OCT_XP_YN_STEEP   = 3'd3;
    localparam logic [OCT_BITS-1:0] OCT_XN_YP_SHALLOW = 3'd4;
    localparam logic [OCT_BITS-1:0] OCT_XN_YP_STEEP   = 3'd5;
    localparam logic [OCT_BITS-1:0] OCT_XN_YN_SHALLOW = 3'd6;
    localparam logic [OCT_BITS-1:0] OCT_XN_YN_STEEP   = 3'd7;

    typedef logic [COORD_BITS-1:0]        t_coord;
    typedef logic signed [DELTA_BITS-1:0] t_delta;
    typedef logic signed [DEC_BITS-1:0]   t_dec;
    typedef logic [OCT_BITS-1:0]          t_oct;

    typedef struct packed {
        logic   is_start;
        t_coord x;
        t_coord y;
        t_coord tx;
        t_coord ty;
        t_delta dx;
        t_delta dy;
        t_dec   dec;
        t_oct   oct;
        logic   last;
    } t_cmd;

endpackage

@@ rtl/mlr_if.sv @@
// ----------------------------------------------------------------------------
// mlr_if
// Valid/ready channels: segment commands in, pixels out.
// ----------------------------------------------------------------------------
interface mlr_cmd_if import mlr_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   op;
    t_coord start_x;
    t_coord start_y;
    t_coord end_x;
    t_coord end_y;

    modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface mlr_pix_if import mlr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord pixel_x;
    t_coord pixel_y;
    logic   last;

    modport source (output valid, pixel_x, pixel_y, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

@@ rtl/mlr_front.sv @@
// ----------------------------------------------------------------------------
// mlr_front
// Accepts command beats, classifies the octant of a start and seeds the
// decision variable.
// ----------------------------------------------------------------------------
module mlr_front import mlr_pkg::*; (
    mlr_cmd_if.sink i_cmd,
    input  logic    i_q_ready,
    output logic    o_q_push,
    output t_cmd    o_cmd
);

    t_delta dx, dy;
    t_delta adx, ady;
    t_dec   ex, ey;
    logic   shallow;
    t_dec   seed;
    t_oct   oct;
    logic   active;

    assign i_cmd.ready = i_q_ready;
    assign o_q_push    = i_cmd.valid & i_q_ready;

    always_comb begin
        dx      = t_delta'({1'b0, i_cmd.end_x}) - t_delta'({1'b0, i_cmd.start_x});
        dy      = t_delta'({1'b0, i_cmd.end_y}) - t_delta'({1'b0, i_cmd.start_y});
        adx     = dx[DELTA_BITS-1] ? -dx : dx;
        ady     = dy[DELTA_BITS-1] ? -dy : dy;
        shallow = ady <= adx;
        ex      = {{(DEC_BITS-DELTA_BITS){dx[DELTA_BITS-1]}}, dx};
        ey      = {{(DEC_BITS-DELTA_BITS){dy[DELTA_BITS-1]}}, dy};
        oct     = {dx[DELTA_BITS-1], dy[DELTA_BITS-1], !shallow};
        priority if (!dx[DELTA_BITS-1] && !dy[DELTA_BITS-1]) begin
            seed = shallow ? ex - (ey <<< 1) : (ex <<< 1) - ey;
        end else if (!dx[DELTA_BITS-1]) begin
            seed = shallow ? -(ex + (ey <<< 1)) : (ex <<< 1) + ey;
        end else if (!dy[DELTA_BITS-1]) begin
            seed = shallow ? -ex - (ey <<< 1) : -(ex <<< 1) - ey;
        end else begin
            seed = shallow ? ex - (ey <<< 1) : (ex <<< 1) - ey;
        end
        active = shallow ? (dx != '0) : (dy != '0);

        o_cmd.is_start = (i_cmd.op == OP_START);
        o_cmd.x        = i_cmd.start_x;
        o_cmd.y        = i_cmd.start_y;
        o_cmd.tx       = i_cmd.end_x;
        o_cmd.ty       = i_cmd.end_y;
        o_cmd.dx       = dx;
        o_cmd.dy       = dy;
        o_cmd.dec      = seed;
        o_cmd.oct      = oct;
        o_cmd.last     = !active;
    end

endmodule

@@ rtl/mlr_queue.sv @@
// ----------------------------------------------------------------------------
// mlr_queue
// Two-entry command queue between the classifier and the stepper.
// ----------------------------------------------------------------------------
module mlr_queue import mlr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/mlr_back.sv @@
// ----------------------------------------------------------------------------
// mlr_back
// Holds the running line, steps the cursor by the octant rule and drives
// the registered pixel output.
// ----------------------------------------------------------------------------
module mlr_back import mlr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    mlr_pix_if.source  o_pix
);

    t_coord r_cx, r_cy, r_tx, r_ty;
    t_delta r_dx, r_dy;
    t_dec   r_dec;
    t_oct   r_oct;
    logic   r_active;

    logic   r_o_valid;
    t_coord r_o_x, r_o_y;
    logic   r_o_last;

    t_dec   ex, ey, term;
    logic   pos, mv_minor, x_step, y_step, done;
    t_coord n_cx, n_cy;
    t_dec   n_dec;

    assign o_pop         = i_valid & (!r_o_valid | o_pix.ready);
    assign o_pix.valid   = r_o_valid;
    assign o_pix.pixel_x = r_o_x;
    assign o_pix.pixel_y = r_o_y;
    assign o_pix.last    = r_o_last;

    always_comb begin
        ex  = {{(DEC_BITS-DELTA_BITS){r_dx[DELTA_BITS-1]}}, r_dx};
        ey  = {{(DEC_BITS-DELTA_BITS){r_dy[DELTA_BITS-1]}}, r_dy};
        pos = !r_dec[DEC_BITS-1];
        unique case (r_oct)
            OCT_XP_YP_SHALLOW: begin
                term     = pos ? -(ey <<< 1) : (ex - ey) <<< 1;
                mv_minor = !pos;
            end
            OCT_XP_YP_STEEP: begin
                term     = pos ? (ex - ey) <<< 1 : ex <<< 1;
                mv_minor = pos;
            end
            OCT_XP_YN_SHALLOW: begin
                term     = pos ? -((ex + ey) <<< 1) : -(ey <<< 1);
                mv_minor = pos;
            end
            OCT_XP_YN_STEEP: begin
                term     = pos ? (ex + ey) <<< 1 : ex <<< 1;
                mv_minor = pos;
            end
            OCT_XN_YP_SHALLOW: begin
                term     = pos ? -(ey <<< 1) : -((ex + ey) <<< 1);
                mv_minor = !pos;
            end
            OCT_XN_YP_STEEP: begin
                term     = pos ? -((ex + ey) <<< 1) : -(ex <<< 1);
                mv_minor = pos;
            end
            OCT_XN_YN_SHALLOW: begin
                term     = pos ? (ex - ey) <<< 1 : -(ey <<< 1);
                mv_minor = pos;
            end
            default: begin
                term     = pos ? ex <<< 1 : (ex - ey) <<< 1;
                mv_minor = !pos;
            end
        endcase
        n_dec  = r_dec + term;
        x_step = r_oct[0] ? mv_minor : 1'b1;
        y_step = r_oct[0] ? 1'b1 : mv_minor;
        n_cx   = x_step ? (r_oct[2] ? r_cx - 1'b1 : r_cx + 1'b1) : r_cx;
        n_cy   = y_step ? (r_oct[1] ? r_cy - 1'b1 : r_cy + 1'b1) : r_cy;
        done   = r_oct[0] ? (n_cy == r_ty) : (n_cx == r_tx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (o_pop && i_cmd.is_start) begin
            r_active  <= !i_cmd.last;
            r_o_valid <= 1'b1;
        end else if (o_pop && r_active) begin
            r_active  <= !done;
            r_o_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.is_start) begin
            r_cx     <= i_cmd.x;
            r_cy     <= i_cmd.y;
            r_tx     <= i_cmd.tx;
            r_ty     <= i_cmd.ty;
            r_dx     <= i_cmd.dx;
            r_dy     <= i_cmd.dy;
            r_dec    <= i_cmd.dec;
            r_oct    <= i_cmd.oct;
            r_o_x    <= i_cmd.x;
            r_o_y    <= i_cmd.y;
            r_o_last <= i_cmd.last;
        end else if (o_pop && r_active) begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_dec    <= n_dec;
            r_o_x    <= n_cx;
            r_o_y    <= n_cy;
            r_o_last <= done;
        end
    end

endmodule

@@ rtl/midpoint_line_rasterizer_core.sv @@
// path: command beat registers in the queue, then in the pixel output register
// throughput: one beat per clock unless stalled, set by the cursor update loop
// a step while no line runs gives no pixel; a start abandons any running line
// reset (synchronous, active low) empties the queue, ends the line, drops output
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_core
// Eight-octant midpoint line rasterizer: classifier, command queue, stepper.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_core import mlr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mlr_cmd_if.sink   i_cmd,
    mlr_pix_if.source o_pix
);

    logic q_ready, q_push, q_valid, q_pop;
    t_cmd front_cmd, q_cmd;

    mlr_front u_front (
        .i_cmd     (i_cmd),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_cmd     (front_cmd)
    );

    mlr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    mlr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (q_pop),
        .o_pix   (o_pix)
    );

endmodule

@@ rtl/mlr_checker.sv @@
// ----------------------------------------------------------------------------
// mlr_checker
// Port-level checks on the rasterizer handshakes and reset behavior.
// ----------------------------------------------------------------------------
module mlr_checker import mlr_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_cmd_valid,
    input logic   i_cmd_ready,
    input logic   i_pix_valid,
    input logic   i_pix_ready,
    input t_coord i_pix_x,
    input t_coord i_pix_y,
    input logic   i_pix_last
);

    // stalled pixel beat holds
    a_pix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !i_pix_ready |=> i_pix_valid && $stable(i_pix_x)
            && $stable(i_pix_y) && $stable(i_pix_last))
        else $error("pixel beat changed while stalled");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pix_valid)
        else $error("pixel valid after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_cmd_ready)
        else $error("command port not ready after reset");

    // an accepted command with a free output is never refused next cycle
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix_valid && i_cmd_valid && i_cmd_ready |=> i_cmd_ready)
        else $error("command port blocked with empty output");

endmodule

bind midpoint_line_rasterizer_core mlr_checker u_mlr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_pix_valid (o_pix.valid),
    .i_pix_ready (o_pix.ready),
    .i_pix_x     (o_pix.pixel_x),
    .i_pix_y     (o_pix.pixel_y),
    .i_pix_last  (o_pix.last)
);
